// File: design/cmcd_pkg.sv
// Shared constants for the capped motion carry drain.
`default_nettype none

package cmcd_pkg;

  // Fixed field widths
  localparam int DELTA_W = 24;
  localparam int EMIT_W  = 16;
  localparam int MPF_W   = 15;
  localparam int THR_W   = 8;
  localparam int CFG_W   = 15;
  localparam int CFG_IDX_W = 1;

  // Default arithmetic geometry
  localparam int FRAC_BITS_DEF  = 8;
  localparam int OWED_WIDTH_DEF = 24;

  // Register reset values
  localparam logic [MPF_W-1:0] MPF_RESET = MPF_W'(127);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(3);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_FRAME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_THRESHOLD = 1'b1;

  // Request codes
  localparam logic REQ_INJECT = 1'b0;
  localparam logic REQ_RETURN = 1'b1;

endpackage

`default_nettype wire

// File: design/capped_motion_carry_drain.sv
// Top level of the capped motion carry drain: input register, drain logic, result register.
`default_nettype none

// Two-axis motion drain. Each input beat carries a request type and signed
// x/y deltas with FRAC_BITS fraction bits. An inject beat adds the deltas to
// the owed motion, then per axis takes owed plus the sub-count residual,
// clamps it to +/- max_per_frame counts, rounds half away from zero and emits
// the whole counts; the residual keeps the rounding remainder and owed keeps
// only what the cap cut off. A return beat adds its deltas (whole counts
// already shifted by FRAC_BITS) into owed and emits zero counts. Every result
// beat also reports pending: either |owed| >= idle_threshold after the update.
// All owed sums saturate at OWED_WIDTH bits. Timing: one beat per cycle
// sustained while out_stall_i is low. Result valid rises after the input
// beat has passed the input register and then the result register, which is
// loaded together with the axis state. Throughput is set by the update loop
// on the owed/residual registers. A stalled result register still lets one
// more beat into the input register. Configuration writes take effect on the
// next beat and are to be made only while the block is idle.
module capped_motion_carry_drain #(
  parameter int FRAC_BITS  = cmcd_pkg::FRAC_BITS_DEF,
  parameter int OWED_WIDTH = cmcd_pkg::OWED_WIDTH_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration
  input  wire logic                                   cfg_we_i,
  input  wire logic [cmcd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [cmcd_pkg::CFG_W-1:0]             cfg_data_i,
  // input channel
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   req_type_i,
  input  wire logic signed [cmcd_pkg::DELTA_W-1:0]    delta_x_i,
  input  wire logic signed [cmcd_pkg::DELTA_W-1:0]    delta_y_i,
  // result channel
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [cmcd_pkg::EMIT_W-1:0]          emit_x_o,
  output logic signed [cmcd_pkg::EMIT_W-1:0]          emit_y_o,
  output logic                                        pending_o
);
  import cmcd_pkg::*;

  // Working width: holds owed + residual with headroom, the shifted cap,
  // and the sign-extended delta sum.
  localparam int CW0 = (OWED_WIDTH + 2 > FRAC_BITS + MPF_W + 2) ?
                       OWED_WIDTH + 2 : FRAC_BITS + MPF_W + 2;
  localparam int CW  = (CW0 > DELTA_W + 2) ? CW0 : DELTA_W + 2;
  localparam int RW  = FRAC_BITS + 1;

  localparam logic signed [CW-1:0] OWED_MAX =
    signed'({{(CW-OWED_WIDTH+1){1'b0}}, {(OWED_WIDTH-1){1'b1}}});
  localparam logic signed [CW-1:0] OWED_MIN =
    signed'({{(CW-OWED_WIDTH+1){1'b1}}, {(OWED_WIDTH-1){1'b0}}});
  localparam logic signed [CW-1:0] HALF_UNIT =
    signed'({{(CW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});

  function automatic logic signed [CW-1:0] sat_owed(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > OWED_MAX) begin
      r = OWED_MAX;
    end else if (v < OWED_MIN) begin
      r = OWED_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MPF_W-1:0] max_per_frame_q;
  logic [THR_W-1:0] idle_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_per_frame_q  <= MPF_RESET;
      idle_threshold_q <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_PER_FRAME:  max_per_frame_q  <= cfg_data_i[MPF_W-1:0];
        REG_IDLE_THRESHOLD: idle_threshold_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register advances into the result register whenever
  // the result register is empty or being drained.
  // ---------------------------------------------------------------------------
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input payload register
  logic                      req_type_q;
  logic signed [DELTA_W-1:0] delta_q [2];

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_type_q <= req_type_i;
      delta_q[0] <= delta_x_i;
      delta_q[1] <= delta_y_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-axis drain
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]     lim;
  logic signed [CW-1:0]     thr;
  logic                     inject;
  logic signed [EMIT_W-1:0] emit_d [2];
  logic [1:0]               axis_pend;

  assign lim = signed'({{(CW-MPF_W-FRAC_BITS){1'b0}}, max_per_frame_q, {FRAC_BITS{1'b0}}});
  assign thr = signed'({{(CW-THR_W){1'b0}}, idle_threshold_q});
  assign inject = (req_type_q == REQ_INJECT);

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [OWED_WIDTH-1:0] owed_q, owed_d;
    logic signed [RW-1:0]         res_q, res_d;
    logic signed [CW-1:0]         owed_ext, delta_ext, owed1, want;
    logic signed [CW-1:0]         capped, mag_c, rounded, cnt, res_full, owed2, owed_new;

    always_comb begin
      owed_ext  = signed'({{(CW-OWED_WIDTH){owed_q[OWED_WIDTH-1]}}, owed_q});
      delta_ext = signed'({{(CW-DELTA_W){delta_q[a][DELTA_W-1]}}, delta_q[a]});
      owed1     = sat_owed(owed_ext + delta_ext);
      want      = owed1 + signed'({{(CW-RW){res_q[RW-1]}}, res_q});

      // clamp to the per-frame cap
      if (want > lim) begin
        capped = lim;
      end else if (want < -lim) begin
        capped = -lim;
      end else begin
        capped = want;
      end

      // round half away from zero on the magnitude
      mag_c    = capped[CW-1] ? -capped : capped;
      rounded  = (mag_c + HALF_UNIT) >>> FRAC_BITS;
      cnt      = capped[CW-1] ? -rounded : rounded;
      res_full = capped - (cnt <<< FRAC_BITS);
      owed2    = sat_owed(want - capped);

      if (inject) begin
        owed_new = owed2;
        res_d    = res_full[RW-1:0];
        emit_d[a] = cnt[EMIT_W-1:0];
      end else begin
        owed_new = owed1;
        res_d    = res_q;
        emit_d[a] = '0;
      end
      owed_d = owed_new[OWED_WIDTH-1:0];

      // |owed| >= threshold, checked after the update
      axis_pend[a] = owed_new[CW-1] ? (-owed_new >= thr) : (owed_new >= thr);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        owed_q <= '0;
        res_q  <= '0;
      end else if (advance) begin
        owed_q <= owed_d;
        res_q  <= res_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic signed [EMIT_W-1:0] emit_x_q, emit_y_q;
  logic                     pending_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      emit_x_q  <= emit_d[0];
      emit_y_q  <= emit_d[1];
      pending_q <= |axis_pend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign emit_x_o    = emit_x_q;
  assign emit_y_o    = emit_y_q;
  assign pending_o   = pending_q;

endmodule

`default_nettype wire
